[rtl/core/arpe_pkg.sv]
package arpe_pkg;

	localparam int BUFFER_BYTES_DEF = 2048;
	localparam int LEN_W = 12;
	localparam int HDR_BYTES = 42;
	localparam int Q_DEPTH = 4;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	localparam logic [1:0] VERD_NONE = 2'd0;
	localparam logic [1:0] VERD_ARP = 2'd1;
	localparam logic [1:0] VERD_ICMP = 2'd2;
	localparam logic [1:0] VERD_OVF = 2'd3;

	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_OWN_IP = 1'b1;

	localparam logic [15:0] ETYPE_ARP = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
	localparam logic [7:0] ARP_OP_REPLY_LO = 8'h02;
	localparam logic [7:0] IP_PROTO_ICMP = 8'h01;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'h08;
	localparam logic [7:0] ICMP_ECHO_REPLY = 8'h00;

	typedef struct packed {
		logic kind;
		logic [1:0] verdict;
		logic [LEN_W-1:0] length;
		logic [7:0] data;
		logic last;
	} result_t;

	typedef struct packed {
		logic valid;
		result_t res;
	} push_t;

	typedef struct packed {
		logic [Q_CNT_W-1:0] count;
	} q_stat_t;

	// one's complement fold of a 32-bit sum down to 16 bits
	function automatic logic [15:0] fold16(input logic [31:0] x);
		logic [16:0] f1;
		f1 = {1'b0, x[15:0]} + {1'b0, x[31:16]};
		return f1[15:0] + {15'd0, f1[16]};
	endfunction

endpackage

[rtl/core/arp_icmp_echo_responder_unit.sv]
// arp / icmp echo responder
// input channel (in_valid/in_stall): operation 0 loads one received frame byte,
// frame_end marks the last one; operation 1 fetches the next reply byte.
// output channel (out_valid/out_stall): one result for a frame's last byte
// (verdict and reply length) and one for every fetch (byte, last flag).
// config: cfg_we writes own_mac (index 0) or own_ip (index 1); write only while idle,
// the block does not enforce this. a result is registered in the s1 stage, then
// written into the result queue and offered at the output from there.
// loads and fetches are taken one per cycle while in_stall is low; the last byte of
// a frame stalls the input while the classifier settles the verdict from
// checksums accumulated during the load.
// reply header bytes come from a shift line, later bytes from the frame ram.
// a four-entry result queue sits before the output; when its entries and the pending
// result reach four, in_stall rises and loads and fetches pause until results leave.
// reset clears counters, pending reply, addresses and the queue; the frame
// ram needs no clearing.
module arp_icmp_echo_responder_unit #(
	parameter int BUFFER_BYTES = arpe_pkg::BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic [7:0] frame_byte,
	input  logic frame_end,
	output logic out_valid,
	input  logic out_stall,
	output logic result_kind,
	output logic [1:0] verdict,
	output logic [arpe_pkg::LEN_W-1:0] reply_length,
	output logic [7:0] reply_byte,
	output logic reply_last,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [47:0] cfg_data
);
	import arpe_pkg::*;

	push_t push;
	q_stat_t qstat;
	result_t res;

	arpe_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .frame_byte(frame_byte), .frame_end(frame_end),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.qstat(qstat), .push(push)
	);

	arpe_back u_back (
		.clk(clk), .arst_n(arst_n),
		.push(push), .qstat(qstat),
		.out_valid(out_valid), .out_stall(out_stall), .res(res)
	);

	assign result_kind = res.kind;
	assign verdict = res.verdict;
	assign reply_length = res.length;
	assign reply_byte = res.data;
	assign reply_last = res.last;

endmodule

[rtl/core/arpe_front.sv]
module arpe_front #(
	parameter int BUFFER_BYTES = arpe_pkg::BUFFER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic [7:0] frame_byte,
	input  logic frame_end,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [47:0] cfg_data,
	input  arpe_pkg::q_stat_t qstat,
	output arpe_pkg::push_t push
);
	import arpe_pkg::*;

	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int ADDR_W = $clog2(BUFFER_BYTES);
	localparam int IS_W = CNT_W + 16;

	logic [7:0] mem [BUFFER_BYTES];
	logic [7:0] mem_rd_q;

	logic [CNT_W-1:0] lc_q, fp_q, plen_q;
	logic ov_q;
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [7:0] hdr_q [HDR_BYTES];
	logic [7:0] rh_q [HDR_BYTES];
	logic [19:0] hsum_q;
	logic [IS_W-1:0] isum_q;

	logic s1_valid, s1_verd, s1_use_mem, s1_last;
	logic [7:0] s1_byte;
	logic [LEN_W-1:0] s1_len;

	logic acc, is_load, first, stored, in_h, in_i;
	logic [CNT_W-1:0] fp_inc;
	logic [15:0] contrib;
	logic [19:0] hsum_d;
	logic [IS_W-1:0] isum_d;

	logic [15:0] etype, len14, hck, ick, ip_new_ck, icmp_new_ck;
	logic [31:0] ip_sum;
	logic arp_ok, ip_ok;
	logic [1:0] verd;
	logic [7:0] rh_n [HDR_BYTES];

	assign in_stall = (s1_valid && s1_verd)
		|| ({1'b0, qstat.count} + {{Q_CNT_W{1'b0}}, s1_valid} >= (Q_CNT_W+1)'(Q_DEPTH));
	assign acc = in_valid && !in_stall;
	assign is_load = (operation == OP_LOAD);
	assign first = (lc_q == '0) && !ov_q;
	assign stored = lc_q < CNT_W'(BUFFER_BYTES);
	assign fp_inc = fp_q + CNT_W'(1);
	assign contrib = lc_q[0] ? {8'd0, frame_byte} : {frame_byte, 8'd0};
	// header checksum field and icmp type/checksum are summed as zero
	assign in_h = (lc_q >= CNT_W'(14)) && (lc_q <= CNT_W'(33))
		&& (lc_q != CNT_W'(24)) && (lc_q != CNT_W'(25));
	assign in_i = (lc_q == CNT_W'(35)) || (lc_q >= CNT_W'(38));
	assign hsum_d = (first ? 20'd0 : hsum_q) + ((in_h && stored) ? {4'd0, contrib} : 20'd0);
	assign isum_d = (first ? IS_W'(0) : isum_q)
		+ ((in_i && stored) ? IS_W'(contrib) : IS_W'(0));

	// end-of-frame classification and reply header build
	always_comb begin
		etype = {hdr_q[12], hdr_q[13]};
		len14 = 16'(lc_q) - 16'd14;
		hck = ~fold16(32'(hsum_q));
		ick = ~fold16(32'(isum_q) + 32'h0000_0800);
		icmp_new_ck = ~fold16(32'(isum_q));
		ip_sum = 32'({hdr_q[14], hdr_q[15]}) + 32'(len14) + 32'({hdr_q[22], hdr_q[23]})
			+ 32'(own_ip_q[31:16]) + 32'(own_ip_q[15:0])
			+ 32'({hdr_q[26], hdr_q[27]}) + 32'({hdr_q[28], hdr_q[29]});
		ip_new_ck = ~fold16(ip_sum);
		arp_ok = (etype == ETYPE_ARP)
			&& ({hdr_q[38], hdr_q[39], hdr_q[40], hdr_q[41]} == own_ip_q)
			&& ({hdr_q[20], hdr_q[21]} == ARP_OP_REQUEST);
		ip_ok = (etype == ETYPE_IPV4)
			&& ({hdr_q[30], hdr_q[31], hdr_q[32], hdr_q[33]} == own_ip_q)
			&& (hdr_q[23] == IP_PROTO_ICMP)
			&& (hck == {hdr_q[24], hdr_q[25]})
			&& (ick == {hdr_q[36], hdr_q[37]})
			&& (hdr_q[34] == ICMP_ECHO_REQUEST);
		priority if (ov_q) verd = VERD_OVF;
		else if (lc_q < CNT_W'(HDR_BYTES)) verd = VERD_NONE;
		else if (arp_ok) verd = VERD_ARP;
		else if (ip_ok) verd = VERD_ICMP;
		else verd = VERD_NONE;

		for (int i = 0; i < HDR_BYTES; i++) rh_n[i] = hdr_q[i];
		for (int i = 0; i < 6; i++) begin
			rh_n[i] = hdr_q[i + 6];
			rh_n[i + 6] = own_mac_q[47 - 8*i -: 8];
		end
		if (etype == ETYPE_ARP) begin
			rh_n[20] = 8'd0;
			rh_n[21] = ARP_OP_REPLY_LO;
			for (int i = 0; i < 6; i++) begin
				rh_n[22 + i] = own_mac_q[47 - 8*i -: 8];
				rh_n[32 + i] = hdr_q[22 + i];
			end
			for (int i = 0; i < 4; i++) begin
				rh_n[28 + i] = own_ip_q[31 - 8*i -: 8];
				rh_n[38 + i] = hdr_q[28 + i];
			end
		end else begin
			rh_n[16] = len14[15:8];
			rh_n[17] = len14[7:0];
			for (int i = 18; i < 22; i++) rh_n[i] = 8'd0;
			rh_n[24] = ip_new_ck[15:8];
			rh_n[25] = ip_new_ck[7:0];
			for (int i = 0; i < 4; i++) begin
				rh_n[26 + i] = own_ip_q[31 - 8*i -: 8];
				rh_n[30 + i] = hdr_q[26 + i];
			end
			rh_n[34] = ICMP_ECHO_REPLY;
			rh_n[36] = icmp_new_ck[15:8];
			rh_n[37] = icmp_new_ck[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_load && stored) mem[lc_q[ADDR_W-1:0]] <= frame_byte;
		mem_rd_q <= mem[fp_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0;
			ov_q <= 1'b0;
			fp_q <= '0;
			plen_q <= '0;
			own_mac_q <= '0;
			own_ip_q <= '0;
			s1_valid <= 1'b0;
			s1_verd <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_OWN_MAC: own_mac_q <= cfg_data;
					REG_OWN_IP: own_ip_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			// only the last byte of a frame and fetches give a result
			s1_valid <= acc && (!is_load || frame_end);
			s1_verd <= acc && is_load && frame_end;
			if (s1_valid && s1_verd) begin
				plen_q <= (verd == VERD_ARP || verd == VERD_ICMP) ? lc_q : '0;
				fp_q <= '0;
				lc_q <= '0;
				ov_q <= 1'b0;
			end else if (acc && is_load) begin
				if (first) begin
					plen_q <= '0;
					fp_q <= '0;
				end
				if (stored) lc_q <= lc_q + CNT_W'(1);
				else ov_q <= 1'b1;
			end else if (acc && fp_q < plen_q) begin
				fp_q <= fp_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_verd) begin
			rh_q <= rh_n;
		end else if (acc && is_load) begin
			hsum_q <= hsum_d;
			isum_q <= isum_d;
			if (stored && lc_q < CNT_W'(HDR_BYTES)) begin
				for (int i = 0; i < HDR_BYTES - 1; i++) hdr_q[i] <= hdr_q[i + 1];
				hdr_q[HDR_BYTES - 1] <= frame_byte;
			end
		end else if (acc && fp_q < plen_q && fp_q < CNT_W'(HDR_BYTES)) begin
			// reply header leaves the shift line one byte per fetch
			for (int i = 0; i < HDR_BYTES - 1; i++) rh_q[i] <= rh_q[i + 1];
		end
		if (acc && !is_load) begin
			if (fp_q < plen_q) begin
				s1_len <= LEN_W'(plen_q);
				s1_last <= fp_inc >= plen_q;
				s1_use_mem <= fp_q >= CNT_W'(HDR_BYTES);
				s1_byte <= rh_q[0];
			end else begin
				s1_len <= '0;
				s1_last <= 1'b1;
				s1_use_mem <= 1'b0;
				s1_byte <= 8'd0;
			end
		end
	end

	always_comb begin
		push.valid = s1_valid;
		if (s1_verd) begin
			push.res.kind = KIND_VERDICT;
			push.res.verdict = verd;
			push.res.length = (verd == VERD_ARP || verd == VERD_ICMP) ? LEN_W'(lc_q) : '0;
			push.res.data = 8'd0;
			push.res.last = 1'b0;
		end else begin
			push.res.kind = KIND_BYTE;
			push.res.verdict = VERD_NONE;
			push.res.length = s1_len;
			push.res.data = s1_use_mem ? mem_rd_q : s1_byte;
			push.res.last = s1_last;
		end
	end

endmodule

[rtl/core/arpe_back.sv]
module arpe_back (
	input  logic clk,
	input  logic arst_n,
	input  arpe_pkg::push_t push,
	output arpe_pkg::q_stat_t qstat,
	output logic out_valid,
	input  logic out_stall,
	output arpe_pkg::result_t res
);
	import arpe_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);

	result_t q_mem [Q_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic pop;

	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && !out_stall;
	assign res = q_mem[rd_q];
	assign qstat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (push.valid) q_mem[wr_q] <= push.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) wr_q <= wr_q + PTR_W'(1);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + Q_CNT_W'(push.valid) - Q_CNT_W'(pop);
		end
	end

endmodule

[rtl/core/arpe_checker.sv]
module arpe_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic result_kind,
	input logic [1:0] verdict,
	input logic [arpe_pkg::LEN_W-1:0] reply_length,
	input logic [7:0] reply_byte,
	input logic reply_last
);
	import arpe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reply_byte) && $stable(verdict))
		else $error("stalled result changed");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_VERDICT |-> reply_byte == 8'd0 && !reply_last)
		else $error("verdict carries byte data");

	a_no_reply_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_VERDICT
		&& (verdict == VERD_NONE || verdict == VERD_OVF) |-> reply_length == '0)
		else $error("dropped frame with reply length");

	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_BYTE && !reply_last |-> reply_length != '0
		&& verdict == VERD_NONE)
		else $error("reply byte without pending reply");

endmodule

bind arp_icmp_echo_responder_unit arpe_checker u_chk (.*);
